// File: design/lsp_pkg.sv
`default_nettype none

package lsp_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int STEP_WIDTH  = 12;
   localparam int ERR_WIDTH   = 18;
   localparam int PT_WIDTH    = COORD_WIDTH + 1;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int CNT_WIDTH   = STEP_WIDTH + 1;
   localparam int SPAN_WIDTH  = COORD_WIDTH + 1;
   localparam int CMP_WIDTH   = (CNT_WIDTH > SPAN_WIDTH) ? CNT_WIDTH : SPAN_WIDTH;
   // running error: carried value plus one minor span, with headroom for the compare
   localparam int ACC_WIDTH   = ((ERR_WIDTH > COORD_WIDTH + 1) ? ERR_WIDTH : COORD_WIDTH + 1) + 2;

   localparam int REQ_BITS    = 4 * COORD_WIDTH + ERR_WIDTH + STEP_WIDTH;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 2 * PT_WIDTH + ERR_WIDTH;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic                        move;
      logic signed [ACC_WIDTH-1:0] err;
   } step_res_type;

endpackage

`default_nettype wire

// File: design/line_step_point_after_n_core.sv
// Line stepper: walks a Bresenham-style line from a start point toward an end
// point for a given number of unit steps and returns the point reached and
// the updated error accumulator.
// Request channel (req_*): one request carries start/end points, the carried
// error and the step count. It is accepted when req_tvalid and req_tready are
// both high; req_tready is high only while the sequencer is idle.
// Response channel (rsp_*): one response per request, held in an output
// register until rsp_tready takes it.
// Sequence: an accepted request runs through the diff, abs and orient states,
// then n = min(max(step_count, 1), major span + 1) steps through the shared
// error/compare unit, then the done state. A degenerate line (start equals
// end) goes from abs straight to done. The next request is taken as soon as
// the result has moved to the output register.
// Stall: while rsp_tready is low a finished result waits in the sequencer's
// done state until the output register frees up; the request side stays
// not ready meanwhile.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any pending response. The block keeps no state between requests.
`default_nettype none

module line_step_point_after_n_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // start_x, start_y, end_x, end_y, error_in, step_count (lowest bits first)
   input  wire logic [lsp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // point_x, point_y, error_out (lowest bits first)
   output logic      [lsp_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int CW = lsp_pkg::COORD_WIDTH;
   localparam int EW = lsp_pkg::ERR_WIDTH;
   localparam int PW = lsp_pkg::PT_WIDTH;
   localparam int AW = lsp_pkg::ACC_WIDTH;
   localparam int NW = lsp_pkg::CNT_WIDTH;
   localparam int MW = lsp_pkg::CMP_WIDTH;
   localparam int SW = lsp_pkg::STEP_WIDTH;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIFF   = 3'd1;
   localparam logic [2:0] ST_ABS    = 3'd2;
   localparam logic [2:0] ST_ORIENT = 3'd3;
   localparam logic [2:0] ST_STEP   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   // request fields
   logic signed [CW-1:0] f_start_x, f_start_y, f_end_x, f_end_y;
   logic signed [EW-1:0] f_error_in;
   logic        [SW-1:0] f_step_count;

   assign f_start_x    = req_tdata[CW-1:0];
   assign f_start_y    = req_tdata[2*CW-1:CW];
   assign f_end_x      = req_tdata[3*CW-1:2*CW];
   assign f_end_y      = req_tdata[4*CW-1:3*CW];
   assign f_error_in   = req_tdata[4*CW+EW-1:4*CW];
   assign f_step_count = req_tdata[4*CW+EW+SW-1:4*CW+EW];

   logic [2:0]                       state_ff, state_in;
   logic signed [CW-1:0]             x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic signed [lsp_pkg::DIFF_WIDTH-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic        [CW-1:0]             adx_ff, adx_in, ady_ff, ady_in;
   logic        [CW-1:0]             major_ff, major_in, minor_ff, minor_in;
   logic                             sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic                             xmaj_ff, xmaj_in;
   logic signed [AW-1:0]             err_ff, err_in;
   logic        [NW-1:0]             cnt_ff, cnt_in;
   logic signed [PW-1:0]             px_ff, px_in, py_ff, py_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic        [lsp_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   lsp_pkg::step_res_type            step_res;
   logic                             req_fire;
   logic                             out_free;
   logic                             sel_xmaj;
   logic        [CW-1:0]             sel_major;
   logic        [MW-1:0]             span_ext, cnt_ext;
   logic        [NW-1:0]             cnt_eff;
   logic signed [PW-1:0]             step_x, step_y;

   lsp_step_unit u_step (
      .err   (err_ff),
      .minor (minor_ff),
      .major (major_ff),
      .res   (step_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // orientation and count clamp, used in the orient state
   assign sel_xmaj  = adx_ff > ady_ff;
   assign sel_major = sel_xmaj ? adx_ff : ady_ff;
   assign cnt_eff   = (cnt_ff == '0) ? {{(NW-1){1'b0}}, 1'b1} : cnt_ff;
   assign span_ext  = {{(MW-CW){1'b0}}, sel_major} + {{(MW-1){1'b0}}, 1'b1};
   assign cnt_ext   = {{(MW-NW){1'b0}}, cnt_eff};

   assign step_x = sx_neg_ff ? {PW{1'b1}} : {{(PW-1){1'b0}}, 1'b1};
   assign step_y = sy_neg_ff ? {PW{1'b1}} : {{(PW-1){1'b0}}, 1'b1};

   always_comb begin
      state_in     = state_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      sx_neg_in    = sx_neg_ff;
      sy_neg_in    = sy_neg_ff;
      xmaj_in      = xmaj_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            // latch the request
            if (req_fire) begin
               x0_in    = f_start_x;
               y0_in    = f_start_y;
               x1_in    = f_end_x;
               y1_in    = f_end_y;
               err_in   = {{(AW-EW){f_error_in[EW-1]}}, f_error_in};
               cnt_in   = {1'b0, f_step_count};
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dx_in    = {x1_ff[CW-1], x1_ff} - {x0_ff[CW-1], x0_ff};
            dy_in    = {y1_ff[CW-1], y1_ff} - {y0_ff[CW-1], y0_ff};
            px_in    = {x0_ff[CW-1], x0_ff};
            py_in    = {y0_ff[CW-1], y0_ff};
            state_in = ST_ABS;
         end
         ST_ABS: begin
            sx_neg_in = dx_ff[lsp_pkg::DIFF_WIDTH-1];
            sy_neg_in = dy_ff[lsp_pkg::DIFF_WIDTH-1];
            adx_in    = dx_ff[lsp_pkg::DIFF_WIDTH-1] ? CW'(-dx_ff) : dx_ff[CW-1:0];
            ady_in    = dy_ff[lsp_pkg::DIFF_WIDTH-1] ? CW'(-dy_ff) : dy_ff[CW-1:0];
            // degenerate line: start point and carried error go out untouched
            if ((dx_ff == '0) && (dy_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ORIENT;
            end
         end
         ST_ORIENT: begin
            xmaj_in  = sel_xmaj;
            major_in = sel_major;
            minor_in = sel_xmaj ? ady_ff : adx_ff;
            // stop one step past the end point
            cnt_in   = (cnt_ext > span_ext) ? span_ext[NW-1:0] : cnt_eff;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            err_in = step_res.err;
            if (xmaj_ff) begin
               px_in = px_ff + step_x;
               if (step_res.move) begin
                  py_in = py_ff + step_y;
               end
            end else begin
               py_in = py_ff + step_y;
               if (step_res.move) begin
                  px_in = px_ff + step_x;
               end
            end
            cnt_in = cnt_ff - {{(NW-1){1'b0}}, 1'b1};
            if (cnt_ff == {{(NW-1){1'b0}}, 1'b1}) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(lsp_pkg::RSP_TDATA_W - lsp_pkg::RSP_BITS){1'b0}},
                               err_ff[EW-1:0], py_ff, px_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      adx_ff      <= adx_in;
      ady_ff      <= ady_in;
      major_ff    <= major_in;
      minor_ff    <= minor_in;
      sx_neg_ff   <= sx_neg_in;
      sy_neg_ff   <= sy_neg_in;
      xmaj_ff     <= xmaj_in;
      err_ff      <= err_in;
      cnt_ff      <= cnt_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_data_ff <= rsp_data_in;
   end

   // the step loop never runs with an exhausted count
   a_step_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (cnt_ff != '0))
      else $error("step loop entered with zero count");

   // a new response appears only out of the done state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");

   // an accepted request always starts the difference stage
   a_req_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_DIFF))
      else $error("accepted request did not start sequencer");

   // leaving done always loads the output register
   a_done_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && (state_in == ST_IDLE)) |=> rsp_tvalid)
      else $error("result dropped on leaving done state");

endmodule

`default_nettype wire

// File: design/lsp_step_unit.sv
`default_nettype none

module lsp_step_unit (
   input  wire logic signed [lsp_pkg::ACC_WIDTH-1:0]   err,
   input  wire logic        [lsp_pkg::COORD_WIDTH-1:0] minor,
   input  wire logic        [lsp_pkg::COORD_WIDTH-1:0] major,
   output lsp_pkg::step_res_type                       res
);

   logic signed [lsp_pkg::ACC_WIDTH-1:0] minor_ext;
   logic signed [lsp_pkg::ACC_WIDTH-1:0] major_ext;
   logic signed [lsp_pkg::ACC_WIDTH-1:0] sum;

   assign minor_ext = {{(lsp_pkg::ACC_WIDTH - lsp_pkg::COORD_WIDTH){1'b0}}, minor};
   assign major_ext = {{(lsp_pkg::ACC_WIDTH - lsp_pkg::COORD_WIDTH){1'b0}}, major};

   // accumulate minor span, pull back by major span once it is exceeded
   always_comb begin
      sum      = err + minor_ext;
      res.move = sum > major_ext;
      res.err  = res.move ? (sum - major_ext) : sum;
   end

endmodule

`default_nettype wire

// File: dv/line_step_point_after_n_core_test.sv
`default_nettype none

module line_step_point_after_n_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW          = lsp_pkg::COORD_WIDTH;
   localparam int EW          = lsp_pkg::ERR_WIDTH;
   localparam int SW          = lsp_pkg::STEP_WIDTH;
   localparam int PW          = lsp_pkg::PT_WIDTH;
   localparam int REQ_BITS    = lsp_pkg::REQ_BITS;
   localparam int REQ_TDATA_W = lsp_pkg::REQ_TDATA_W;
   localparam int RSP_BITS    = lsp_pkg::RSP_BITS;
   localparam int RSP_TDATA_W = lsp_pkg::RSP_TDATA_W;

   // Abort when nothing moves on either channel for this many cycles. The slowest
   // request walks 4095 steps; add the long output hold-off and take it a few
   // times over.
   localparam int WATCHDOG_LIMIT = 20000;
   // Length of the output hold-off used to fill the block and stall its input.
   localparam int HOLD_OFF_CYCLES = 400;
   // Quiet cycles after the last response, to catch any stray extra response.
   localparam int DRAIN_CYCLES = 64;

   // One request, first field in the lowest bits.
   typedef struct packed {
      logic        [SW-1:0] step_count;
      logic signed [EW-1:0] error_in;
      logic signed [CW-1:0] end_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] start_x;
   } line_req_type;

   // One response, first field in the lowest bits.
   typedef struct packed {
      logic signed [EW-1:0] error_out;
      logic signed [PW-1:0] point_y;
      logic signed [PW-1:0] point_x;
   } line_point_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   line_point_type expected_points[$];
   int             mismatch_count;
   int             quiet_cycles;

   // Stimulus knobs: random gaps on the request side, random stalls on the
   // response side, and a one-shot long hold-off request for the receiver.
   bit          sender_gaps;
   bit          receiver_stalls;
   bit          hold_off_req;
   int          stall_left;

   line_step_point_after_n_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Walk the line the way the block does: one unit step on the major axis per
   // iteration, minor axis moves when the running error passes the major span.
   // The running error is kept wide; only the returned error wraps.
   function automatic line_point_type walk_line(line_req_type r);
      longint         x0, y0, x1, y1, acc;
      longint         dx, dy, sx, sy, major, minor, n, px, py;
      bit             x_major, moved;
      line_point_type o;
      x0  = r.start_x;
      y0  = r.start_y;
      x1  = r.end_x;
      y1  = r.end_y;
      acc = r.error_in;
      px  = x0;
      py  = y0;
      if (x0 != x1 || y0 != y1) begin
         dx = x1 - x0;
         dy = y1 - y0;
         sx = 1;
         sy = 1;
         if (dx < 0) begin
            sx = -1;
            dx = -dx;
         end
         if (dy < 0) begin
            sy = -1;
            dy = -dy;
         end
         // ties go to y
         x_major = dx > dy;
         major   = x_major ? dx : dy;
         minor   = x_major ? dy : dx;
         // a count of zero still takes one step; stop one step past the end
         if (r.step_count == 0)
            n = 1;
         else
            n = r.step_count;
         if (n > major + 1)
            n = major + 1;
         for (longint i = 0; i < n; i++) begin
            acc   = acc + minor;
            moved = acc > major;
            if (moved)
               acc = acc - major;
            if (x_major) begin
               px = px + sx;
               if (moved)
                  py = py + sy;
            end else begin
               py = py + sy;
               if (moved)
                  px = px + sx;
            end
         end
      end
      o.point_x   = px[PW-1:0];
      o.point_y   = py[PW-1:0];
      o.error_out = acc[EW-1:0];
      return o;
   endfunction

   function automatic line_req_type make_line(int sx, int sy, int ex, int ey, int err, int cnt);
      line_req_type r;
      r.start_x    = CW'(sx);
      r.start_y    = CW'(sy);
      r.end_x      = CW'(ex);
      r.end_y      = CW'(ey);
      r.error_in   = EW'(err);
      r.step_count = SW'(cnt);
      return r;
   endfunction

   // Random request. Most lines are short so the walk stays brief; a few use
   // the whole coordinate range and the whole step count range.
   function automatic line_req_type random_line();
      line_req_type r;
      int           kind;
      int           d;
      kind      = $urandom_range(0, 9);
      r.start_x = CW'($urandom);
      r.start_y = CW'($urandom);
      r.end_x   = CW'($urandom);
      r.end_y   = CW'($urandom);
      case (kind)
         0: begin
            // degenerate: start equals end
            r.end_x = r.start_x;
            r.end_y = r.start_y;
         end
         1, 2: begin
            // full-range endpoints as drawn
         end
         6: begin
            // horizontal or vertical
            if ($urandom_range(0, 1)) begin
               r.end_x = CW'(r.start_x + ($urandom_range(0, 80) - 40));
               r.end_y = r.start_y;
            end else begin
               r.end_x = r.start_x;
               r.end_y = CW'(r.start_y + ($urandom_range(0, 80) - 40));
            end
         end
         7: begin
            // diagonal: equal spans, y wins the tie
            d       = $urandom_range(1, 40);
            r.end_x = $urandom_range(0, 1) ? CW'(r.start_x + d) : CW'(r.start_x - d);
            r.end_y = $urandom_range(0, 1) ? CW'(r.start_y + d) : CW'(r.start_y - d);
         end
         default: begin
            r.end_x = CW'(r.start_x + ($urandom_range(0, 80) - 40));
            r.end_y = CW'(r.start_y + ($urandom_range(0, 80) - 40));
         end
      endcase
      if ($urandom_range(0, 1))
         r.error_in = EW'($urandom);
      else
         r.error_in = EW'($urandom_range(0, 255) - 128);
      if ($urandom_range(0, 15) == 0)
         r.step_count = SW'($urandom);
      else if (kind >= 8)
         r.step_count = SW'($urandom_range(40, 100));  // run past the end point
      else
         r.step_count = SW'($urandom_range(0, 63));
      return r;
   endfunction

   // Offer one request and hold it until the block takes it. Valid stays high
   // afterwards; the next call either redrives it or drops it at the next
   // falling edge, so it is never lowered and raised in the same step.
   task automatic send_line(input line_req_type r);
      int gap;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tdata  = {{(REQ_TDATA_W-REQ_BITS){1'b0}}, r};
      req_tvalid = 1'b1;
      forever begin
         @(posedge clock);
         if (req_tready)
            break;
      end
      expected_points.push_back(walk_line(r));
   endtask

   // Extremes of every field, both axis orders and directions, the tie,
   // degenerate lines, zero count and counts that overrun the end point.
   task automatic test_directed_edges();
      send_line(make_line(0, 0, 0, 0, 0, 5));
      send_line(make_line(-32768, 32767, -32768, 32767, -131072, 4095));
      send_line(make_line(32767, -32768, 32767, -32768, 131071, 0));
      send_line(make_line(0, 0, 10, 3, 0, 0));
      send_line(make_line(0, 0, 10, 3, 0, 1));
      send_line(make_line(0, 0, 10, 3, 0, 4095));
      send_line(make_line(5, 5, 25, 12, 3, 8));
      send_line(make_line(5, 5, -15, -2, -4, 8));
      send_line(make_line(0, 0, 3, 17, 0, 9));
      send_line(make_line(0, 0, -7, -20, 9, 12));
      send_line(make_line(0, 0, 6, 6, 0, 4));
      send_line(make_line(0, 0, -6, 6, 2, 7));
      send_line(make_line(100, -4, 130, -4, 0, 40));
      send_line(make_line(-3, 0, -3, -25, -1, 26));
      send_line(make_line(-32768, 0, 32767, 1, 0, 4095));
      send_line(make_line(0, 32767, 5, -32768, 131071, 4095));
      send_line(make_line(-32768, -32768, 32767, 32767, -131072, 4095));
      send_line(make_line(1, 1, 9, 4, 131071, 6));
      send_line(make_line(1, 1, 9, 4, -131072, 6));
      send_line(make_line(32767, 32767, -32768, -32768, -1, 1));
      send_line(make_line(32767, -32768, -32768, 32767, 65535, 4095));
      send_line(make_line(0, 0, -32768, 100, 12345, 2048));
   endtask

   // Bulk random requests with idling on both sides.
   task automatic test_random_lines(input int count);
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      repeat (count) send_line(random_line());
   endtask

   // Hold the response side off for a long stretch while requests keep coming,
   // so the output register and the sequencer fill and the input stalls.
   task automatic test_output_backpressure();
      sender_gaps  = 1'b0;
      hold_off_req = 1'b1;
      repeat (16) send_line(random_line());
   endtask

   // Closing stretch: no idling on either side.
   task automatic test_back_to_back(input int count);
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      repeat (count) send_line(random_line());
   endtask

   // Receiver: random stall bursts, plus the long hold-off when requested.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left = stall_left - 1;
      end else if (hold_off_req) begin
         rsp_tready   = 1'b0;
         stall_left   = HOLD_OFF_CYCLES - 1;
         hold_off_req = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Compare every response against the oldest pending expectation.
   always @(posedge clock) begin
      line_point_type got;
      line_point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_BITS-1:0];
         if (expected_points.size() == 0) begin
            $error("unexpected response: point_x %0d point_y %0d error_out %0d",
                   got.point_x, got.point_y, got.error_out);
            mismatch_count++;
         end else begin
            want = expected_points.pop_front();
            if (got.point_x !== want.point_x) begin
               $error("point_x: expected %0d, actual %0d", want.point_x, got.point_x);
               mismatch_count++;
            end
            if (got.point_y !== want.point_y) begin
               $error("point_y: expected %0d, actual %0d", want.point_y, got.point_y);
               mismatch_count++;
            end
            if (got.error_out !== want.error_out) begin
               $error("error_out: expected %0d, actual %0d", want.error_out, got.error_out);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a request.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      rsp_tready      = 1'b0;
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      hold_off_req    = 1'b0;
      stall_left      = 0;
      mismatch_count  = 0;
      quiet_cycles    = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_random_lines(1100);
      test_output_backpressure();
      test_random_lines(50);
      test_back_to_back(100);

      // drop valid so the last request is not taken twice, then drain
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
